@@ hw/rtl/color_sensor_frequency_sequencer_core_assert.svh @@
// Assertion macros shared by the color sensor frequency sequencer RTL.
`ifndef COLOR_SENSOR_FREQUENCY_SEQUENCER_CORE_ASSERT_SVH
`define COLOR_SENSOR_FREQUENCY_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CSFS_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("csfs same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CSFS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("csfs next-cycle check failed");

`endif

@@ hw/rtl/csfs_pkg.sv @@
// Shared constants and types of the color sensor frequency sequencer.
package csfs_pkg;

	localparam int TIME_BITS_DEFAULT = 16;
	localparam int CAPTURE_BITS      = 16;
	localparam int VALUE_BITS        = 16;
	localparam int COLOR_BITS        = 2;
	localparam int CFG_BITS          = 32;
	localparam int DIVIDEND_BITS     = 32;

	localparam logic [VALUE_BITS-1:0] SAT_MAX         = 16'hFFFF;
	localparam logic [CFG_BITS-1:0]   REF_CLOCK_RESET = 32'd1000000;

	localparam logic [COLOR_BITS-1:0] COLOR_RED   = 2'd0;
	localparam logic [COLOR_BITS-1:0] COLOR_GREEN = 2'd1;
	localparam logic [COLOR_BITS-1:0] COLOR_BLUE  = 2'd2;

	localparam logic [1:0] PIN_RED   = 2'd0;
	localparam logic [1:0] PIN_BLUE  = 2'd1;
	localparam logic [1:0] PIN_GREEN = 2'd3;

	typedef struct packed {
		logic capture_first;
		logic start_div;
		logic div_step;
		logic commit;
	} csfs_cmd_t;

endpackage

@@ hw/rtl/csfs_in_if.sv @@
// Request channel carrying one capture timestamp.
interface csfs_in_if;
	logic                                valid;
	logic                                ready;
	logic [csfs_pkg::CAPTURE_BITS-1:0]   capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink (input valid, input capture_time, output ready);
endinterface

@@ hw/rtl/csfs_out_if.sv @@
// Request channel carrying one color measurement result.
interface csfs_out_if;
	logic                              valid;
	logic                              ready;
	logic [csfs_pkg::COLOR_BITS-1:0]   measured_color;
	logic [csfs_pkg::VALUE_BITS-1:0]   measured_value;
	logic [1:0]                        filter_select;
	logic [csfs_pkg::VALUE_BITS-1:0]   red_value;
	logic [csfs_pkg::VALUE_BITS-1:0]   green_value;
	logic [csfs_pkg::VALUE_BITS-1:0]   blue_value;
	logic                              floor_is_red;

	modport source (output valid, output measured_color, output measured_value,
		output filter_select, output red_value, output green_value, output blue_value,
		output floor_is_red, input ready);
	modport sink (input valid, input measured_color, input measured_value,
		input filter_select, input red_value, input green_value, input blue_value,
		input floor_is_red, output ready);
endinterface

@@ hw/rtl/color_sensor_frequency_sequencer_core.sv @@
// Top level of the color sensor frequency sequencer.
//
// The sample channel takes one capture timestamp per request. Captures are
// paired: the first of a pair is stored and returns nothing, the second closes
// a period and produces one request on the result channel.
// The frequency is the reference clock register divided by the period, found
// by a restoring divider that yields one quotient bit per cycle. A closing
// capture starts the division in ST_DIVIDE; ST_FINISH then commits the result
// to the output register, and the block takes the next capture in the same
// cycle as the result appears. An opening capture starts no division and leaves the block ready.
// The result sits in an output register; the block keeps accepting captures
// while it waits there, and only a finished division stalls until the
// receiver takes the previous result.
// cfg_write_en and cfg_write_data load the reference clock register at once.
// Reset clears all stored frequencies and the red flag, restarts the color
// sequence at red, drops any half-finished capture pair and sets the
// reference clock to 1000000.
`include "color_sensor_frequency_sequencer_core_assert.svh"

module color_sensor_frequency_sequencer_core #(
	parameter int TIME_BITS = csfs_pkg::TIME_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [csfs_pkg::CFG_BITS-1:0] cfg_write_data,
	csfs_in_if.sink                       sample,
	csfs_out_if.source                    result
);

	csfs_pkg::csfs_cmd_t cmd;

	csfs_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	csfs_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.capture_time   (sample.capture_time),
		.cmd            (cmd),
		.measured_color (result.measured_color),
		.measured_value (result.measured_value),
		.filter_select  (result.filter_select),
		.red_value      (result.red_value),
		.green_value    (result.green_value),
		.blue_value     (result.blue_value),
		.floor_is_red   (result.floor_is_red)
	);

	`CSFS_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.commit, !(result.valid && !result.ready))
	`CSFS_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, result.valid)
	`CSFS_ASSERT_SAME(a_busy_no_take, clk, arst_n, cmd.div_step, !sample.ready)
	`CSFS_ASSERT_NEXT(a_start_steps, clk, arst_n, cmd.start_div, cmd.div_step)

endmodule

@@ hw/rtl/csfs_controller.sv @@
// Sequencing state machine: pairs captures, runs the divider, hands off results.
module csfs_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	output logic                result_valid,
	input  logic                result_ready,
	output csfs_pkg::csfs_cmd_t cmd
);

	localparam int CNT_BITS = $clog2(csfs_pkg::DIVIDEND_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(csfs_pkg::DIVIDEND_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic                have_first_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                accept;
	logic                slot_free;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (have_first_q) begin
						cmd.start_div = 1'b1;
						state_d       = ST_DIVIDE;
					end else begin
						cmd.capture_first = 1'b1;
					end
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_first_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture_first) begin
				have_first_q <= 1'b1;
			end else if (cmd.start_div) begin
				have_first_q <= 1'b0;
			end
			if (cmd.start_div) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/csfs_datapath.sv @@
// Period capture, restoring divider, color stores and result register.
module csfs_datapath #(
	parameter int TIME_BITS = csfs_pkg::TIME_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [csfs_pkg::CFG_BITS-1:0]       cfg_write_data,
	input  logic [csfs_pkg::CAPTURE_BITS-1:0]   capture_time,
	input  csfs_pkg::csfs_cmd_t                 cmd,
	output logic [csfs_pkg::COLOR_BITS-1:0]     measured_color,
	output logic [csfs_pkg::VALUE_BITS-1:0]     measured_value,
	output logic [1:0]                          filter_select,
	output logic [csfs_pkg::VALUE_BITS-1:0]     red_value,
	output logic [csfs_pkg::VALUE_BITS-1:0]     green_value,
	output logic [csfs_pkg::VALUE_BITS-1:0]     blue_value,
	output logic                                floor_is_red
);

	localparam int QB = csfs_pkg::DIVIDEND_BITS;
	localparam int VB = csfs_pkg::VALUE_BITS;
	localparam int CB = csfs_pkg::COLOR_BITS;

	logic [QB-1:0]        cap_ext;
	logic [TIME_BITS-1:0] now_time;
	logic [TIME_BITS-1:0] first_edge_q;
	logic [TIME_BITS-1:0] divisor_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [QB-1:0]        quo_q;
	logic [csfs_pkg::CFG_BITS-1:0] ref_clock_q;
	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS:0]   diff;
	logic                 fits;

	logic [CB-1:0] color_q;
	logic [VB-1:0] red_q;
	logic [VB-1:0] green_q;
	logic [VB-1:0] blue_q;
	logic          flag_q;

	logic [VB-1:0] freq;
	logic [VB-1:0] red_n;
	logic [VB-1:0] green_n;
	logic [VB-1:0] blue_n;
	logic [CB-1:0] color_n;
	logic [CB-1:0] meas_n;
	logic [1:0]    pins_n;
	logic          flag_n;

	logic [CB-1:0] measured_color_q;
	logic [VB-1:0] measured_value_q;
	logic [1:0]    filter_select_q;

	assign cap_ext  = QB'(capture_time);
	assign now_time = cap_ext[TIME_BITS-1:0];

	// One quotient bit per step; a zero divisor yields all ones and so saturates.
	assign trial = {rem_q, quo_q[QB-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = (trial >= {1'b0, divisor_q});

	assign freq = (|quo_q[QB-1:VB]) ? csfs_pkg::SAT_MAX : quo_q[VB-1:0];

	always_comb begin
		red_n   = red_q;
		green_n = green_q;
		blue_n  = blue_q;
		unique case (color_q)
			csfs_pkg::COLOR_GREEN: begin
				green_n = freq;
				meas_n  = csfs_pkg::COLOR_GREEN;
				color_n = csfs_pkg::COLOR_BLUE;
				pins_n  = csfs_pkg::PIN_BLUE;
			end
			csfs_pkg::COLOR_BLUE: begin
				blue_n  = freq;
				meas_n  = csfs_pkg::COLOR_BLUE;
				color_n = csfs_pkg::COLOR_RED;
				pins_n  = csfs_pkg::PIN_RED;
			end
			default: begin
				red_n   = freq;
				meas_n  = csfs_pkg::COLOR_RED;
				color_n = csfs_pkg::COLOR_GREEN;
				pins_n  = csfs_pkg::PIN_GREEN;
			end
		endcase
		flag_n = ({1'b0, red_n} >= {green_n, 1'b0}) && ({1'b0, red_n} >= {blue_n, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q  <= csfs_pkg::REF_CLOCK_RESET;
			first_edge_q <= '0;
			color_q      <= csfs_pkg::COLOR_RED;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			flag_q       <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				ref_clock_q <= cfg_write_data;
			end
			if (cmd.capture_first) begin
				first_edge_q <= now_time;
			end
			if (cmd.commit) begin
				color_q <= color_n;
				red_q   <= red_n;
				green_q <= green_n;
				blue_q  <= blue_n;
				flag_q  <= flag_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			divisor_q <= now_time - first_edge_q;
			rem_q     <= '0;
			quo_q     <= ref_clock_q;
		end else if (cmd.div_step) begin
			rem_q <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[QB-2:0], fits};
		end
		if (cmd.commit) begin
			measured_color_q <= meas_n;
			measured_value_q <= freq;
			filter_select_q  <= pins_n;
		end
	end

	assign measured_color = measured_color_q;
	assign measured_value = measured_value_q;
	assign filter_select  = filter_select_q;
	assign red_value      = red_q;
	assign green_value    = green_q;
	assign blue_value     = blue_q;
	assign floor_is_red   = flag_q;

endmodule
